### rtl/core/assert_macros.svh
// Assertion macros used by the date difference top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on the rising clock edge, ignored while reset is high.
`define DD_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define DD_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/core/dd_pkg.sv
// Shared types, constants and calendar tables of the date difference block.
package dd_pkg;

   localparam int YEAR_W  = 14;
   localparam int MONTH_W = 4;
   localparam int DAY_W   = 5;
   localparam int NUM_W   = 23;
   localparam int DIFF_W  = 23;
   localparam int QUOT_W  = 8;

   localparam int RECIP_100   = 5243;
   localparam int RECIP_SHIFT = 19;

   localparam logic [NUM_W-1:0] DIFF_LIMIT = 23'd3652426;

   localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
   localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
   localparam logic [MONTH_W-1:0] MONTH_MAR = 4'd3;
   localparam logic [MONTH_W-1:0] MONTH_APR = 4'd4;
   localparam logic [MONTH_W-1:0] MONTH_MAY = 4'd5;
   localparam logic [MONTH_W-1:0] MONTH_JUN = 4'd6;
   localparam logic [MONTH_W-1:0] MONTH_JUL = 4'd7;
   localparam logic [MONTH_W-1:0] MONTH_AUG = 4'd8;
   localparam logic [MONTH_W-1:0] MONTH_SEP = 4'd9;
   localparam logic [MONTH_W-1:0] MONTH_OCT = 4'd10;
   localparam logic [MONTH_W-1:0] MONTH_NOV = 4'd11;
   localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

   typedef struct packed {
      logic s1;
      logic s2;
      logic s3;
      logic s4;
      logic s5;
   } stage_en_type;

   function automatic logic [8:0] days_before_month(input logic [MONTH_W-1:0] m);
      logic [8:0] n;
      case (m)
         MONTH_JAN: n = 9'd0;
         MONTH_FEB: n = 9'd31;
         MONTH_MAR: n = 9'd59;
         MONTH_APR: n = 9'd90;
         MONTH_MAY: n = 9'd120;
         MONTH_JUN: n = 9'd151;
         MONTH_JUL: n = 9'd181;
         MONTH_AUG: n = 9'd212;
         MONTH_SEP: n = 9'd243;
         MONTH_OCT: n = 9'd273;
         MONTH_NOV: n = 9'd304;
         MONTH_DEC: n = 9'd334;
         default:   n = 9'd0;
      endcase
      return n;
   endfunction

   function automatic logic [DAY_W-1:0] month_length(input logic [MONTH_W-1:0] m,
                                                     input logic leap);
      logic [DAY_W-1:0] len;
      case (m)
         MONTH_FEB: len = leap ? 5'd29 : 5'd28;
         MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = 5'd30;
         MONTH_JAN, MONTH_MAR, MONTH_MAY, MONTH_JUL,
         MONTH_AUG, MONTH_OCT, MONTH_DEC: len = 5'd31;
         default: len = 5'd0;
      endcase
      return len;
   endfunction

endpackage

### rtl/core/dd_day_count.sv
// Three-stage conversion of one date into a day number and a validity flag.
module dd_day_count (
   input  logic                          clock,
   input  dd_pkg::stage_en_type          en,
   input  logic [dd_pkg::YEAR_W-1:0]     year,
   input  logic [dd_pkg::MONTH_W-1:0]    month,
   input  logic [dd_pkg::DAY_W-1:0]      day,
   output logic [dd_pkg::NUM_W-1:0]      day_num,
   output logic                          date_ok
);

   localparam int PW = 28;

   logic [14:0]   y99;
   logic [14:0]   y399;
   logic [PW-1:0] prod_y;
   logic [PW-1:0] prod_b;
   logic [PW-1:0] prod_c;

   logic [dd_pkg::YEAR_W-1:0]  y_ff;
   logic [dd_pkg::MONTH_W-1:0] m_ff;
   logic [dd_pkg::DAY_W-1:0]   d_ff;
   logic [dd_pkg::QUOT_W-1:0]  q_ff;
   logic [dd_pkg::QUOT_W-1:0]  b_ff;
   logic [dd_pkg::QUOT_W-1:0]  c_ff;

   logic [dd_pkg::YEAR_W-1:0]  rem;
   logic                       leap;
   logic [dd_pkg::DAY_W-1:0]   len;
   logic                       ok_in;
   logic [dd_pkg::NUM_W-1:0]   partial_in;
   logic [12:0]                quad;
   logic [12:0]                leaps_in;

   logic [dd_pkg::NUM_W-1:0]   partial_ff;
   logic [12:0]                leaps_ff;
   logic                       ok2_ff;
   logic [dd_pkg::NUM_W-1:0]   day_num_ff;
   logic                       ok3_ff;

   always_comb begin
      y99    = {1'b0, year} + 15'd99;
      y399   = {1'b0, year} + 15'd399;
      prod_y = PW'(year) * PW'(dd_pkg::RECIP_100);
      prod_b = PW'(y99) * PW'(dd_pkg::RECIP_100);
      prod_c = PW'(y399) * PW'(dd_pkg::RECIP_100);
   end

   always_ff @(posedge clock) begin
      if (en.s1) begin
         y_ff <= year;
         m_ff <= month;
         d_ff <= day;
         q_ff <= prod_y[dd_pkg::RECIP_SHIFT +: dd_pkg::QUOT_W];
         b_ff <= prod_b[dd_pkg::RECIP_SHIFT +: dd_pkg::QUOT_W];
         c_ff <= prod_c[dd_pkg::RECIP_SHIFT +: dd_pkg::QUOT_W];
      end
   end

   always_comb begin
      rem   = y_ff - (14'(q_ff) * 14'd100);
      leap  = ((y_ff[1:0] == 2'b00) && (rem != '0)) || ((rem == '0) && (q_ff[1:0] == 2'b00));
      len   = dd_pkg::month_length(m_ff, leap);
      ok_in = (len != '0) && (d_ff != '0) && (d_ff <= len);
      partial_in = (23'(y_ff) * 23'd365) + 23'(dd_pkg::days_before_month(m_ff))
                 + 23'(d_ff) - 23'd1 + 23'((m_ff > dd_pkg::MONTH_FEB) && leap);
      quad     = 13'(({1'b0, y_ff} + 15'd3) >> 2);
      leaps_in = quad - 13'(b_ff) + 13'(c_ff >> 2);
   end

   always_ff @(posedge clock) begin
      if (en.s2) begin
         partial_ff <= partial_in;
         leaps_ff   <= leaps_in;
         ok2_ff     <= ok_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en.s3) begin
         day_num_ff <= partial_ff + 23'(leaps_ff);
         ok3_ff     <= ok2_ff;
      end
   end

   assign day_num = day_num_ff;
   assign date_ok = ok3_ff;

endmodule

### rtl/core/dd_diff.sv
// Two-stage signed difference, end-day adjustment and saturation of two day numbers.
module dd_diff (
   input  logic                          clock,
   input  dd_pkg::stage_en_type          en,
   input  logic [dd_pkg::NUM_W-1:0]      first_num,
   input  logic                          first_ok,
   input  logic [dd_pkg::NUM_W-1:0]      second_num,
   input  logic                          second_ok,
   input  logic                          include_end,
   output logic [dd_pkg::DIFF_W-1:0]     day_difference,
   output logic                          date_error
);

   logic                        neg_in;
   logic [dd_pkg::NUM_W-1:0]    mag_in;
   logic                        neg_ff;
   logic                        err4_ff;
   logic [dd_pkg::NUM_W-1:0]    mag_ff;

   logic [dd_pkg::NUM_W-1:0]    sat;
   logic [dd_pkg::DIFF_W-1:0]   diff_in;
   logic [dd_pkg::DIFF_W-1:0]   diff_ff;
   logic                        err5_ff;

   always_comb begin
      neg_in = first_num > second_num;
      mag_in = (neg_in ? (first_num - second_num) : (second_num - first_num))
             + 23'(include_end);
   end

   always_ff @(posedge clock) begin
      if (en.s4) begin
         neg_ff  <= neg_in;
         mag_ff  <= mag_in;
         err4_ff <= !(first_ok && second_ok);
      end
   end

   always_comb begin
      sat = (mag_ff > dd_pkg::DIFF_LIMIT) ? dd_pkg::DIFF_LIMIT : mag_ff;
      if (err4_ff) begin
         diff_in = '0;
      end else if (neg_ff) begin
         diff_in = (~sat) + 23'd1;
      end else begin
         diff_in = sat;
      end
   end

   always_ff @(posedge clock) begin
      if (en.s5) begin
         diff_ff <= diff_in;
         err5_ff <= err4_ff;
      end
   end

   assign day_difference = diff_ff;
   assign date_error     = err5_ff;

endmodule

### rtl/core/date_difference_days.sv
// Top level of the pipelined Gregorian date difference block.
//
// Usage:
//   The req channel carries one pair of dates per transaction; req_tuser is the
//   include-end flag. The rsp channel returns one transaction per request: the
//   signed day count from the first date to the second in rsp_tdata and the
//   invalid-date flag in rsp_tuser (difference forced to zero when set).
//   Five register stages lie between request and result. Throughput: one
//   transaction per cycle while the receiver does not stall, set by the five-stage
//   pipeline (reciprocal divide by 100, leap and calendar sums, day number
//   sum, difference, saturation), each stage advancing on its own enable.
//   Reset empties every stage; rsp_tvalid is low after reset.
//   When the receiver stalls, the pipeline compacts its bubbles and then
//   holds; req_tready drops only once all five stages are full.
`include "assert_macros.svh"

module date_difference_days (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // first_year[13:0], first_month[17:14], first_day[22:18],
   // second_year[36:23], second_month[40:37], second_day[45:41], zero[47:46]
   input  logic [47:0] req_tdata,
   // include_end[0]
   input  logic        req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // day_difference[22:0], zero[23]
   output logic [23:0] rsp_tdata,
   // date_error[0]
   output logic        rsp_tuser
);

   localparam int STAGES = 5;

   dd_pkg::stage_en_type en;
   logic [STAGES-1:0]    v_ff;
   logic [STAGES-1:0]    v_in;
   logic [2:0]           incl_ff;

   logic [dd_pkg::NUM_W-1:0]  first_num;
   logic                      first_ok;
   logic [dd_pkg::NUM_W-1:0]  second_num;
   logic                      second_ok;
   logic [dd_pkg::DIFF_W-1:0] day_difference;
   logic                      date_error;
   logic [dd_pkg::DIFF_W-1:0] diff_mag;

   always_comb begin
      en.s5 = !v_ff[4] || rsp_tready;
      en.s4 = !v_ff[3] || en.s5;
      en.s3 = !v_ff[2] || en.s4;
      en.s2 = !v_ff[1] || en.s3;
      en.s1 = !v_ff[0] || en.s2;
      v_in[0] = en.s1 ? req_tvalid : v_ff[0];
      v_in[1] = en.s2 ? v_ff[0] : v_ff[1];
      v_in[2] = en.s3 ? v_ff[1] : v_ff[2];
      v_in[3] = en.s4 ? v_ff[2] : v_ff[3];
      v_in[4] = en.s5 ? v_ff[3] : v_ff[4];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en.s1) begin
         incl_ff[0] <= req_tuser;
      end
      if (en.s2) begin
         incl_ff[1] <= incl_ff[0];
      end
      if (en.s3) begin
         incl_ff[2] <= incl_ff[1];
      end
   end

   dd_day_count u_first (
      .clock   (clock),
      .en      (en),
      .year    (req_tdata[13:0]),
      .month   (req_tdata[17:14]),
      .day     (req_tdata[22:18]),
      .day_num (first_num),
      .date_ok (first_ok)
   );

   dd_day_count u_second (
      .clock   (clock),
      .en      (en),
      .year    (req_tdata[36:23]),
      .month   (req_tdata[40:37]),
      .day     (req_tdata[45:41]),
      .day_num (second_num),
      .date_ok (second_ok)
   );

   dd_diff u_diff (
      .clock          (clock),
      .en             (en),
      .first_num      (first_num),
      .first_ok       (first_ok),
      .second_num     (second_num),
      .second_ok      (second_ok),
      .include_end    (incl_ff[2]),
      .day_difference (day_difference),
      .date_error     (date_error)
   );

   assign req_tready = en.s1;
   assign rsp_tvalid = v_ff[4];
   assign rsp_tdata  = {1'b0, day_difference};
   assign rsp_tuser  = date_error;

   assign diff_mag = day_difference[dd_pkg::DIFF_W-1] ? ((~day_difference) + 23'd1)
                                                      : day_difference;

   `DD_ASSERT_ALWAYS(a_reset_empties, clock, reset |=> (v_ff == '0), "pipeline not empty after reset")
   `DD_ASSERT(a_stall_full, clock, reset, !req_tready |-> (&v_ff), "request stalled with a bubble in the pipeline")
   `DD_ASSERT(a_error_zero, clock, reset, (rsp_tvalid && rsp_tuser) |-> (rsp_tdata == '0), "nonzero difference on date error")
   `DD_ASSERT(a_limit, clock, reset, rsp_tvalid |-> (diff_mag <= dd_pkg::DIFF_LIMIT), "difference beyond limit")

endmodule

### tb/date_difference_days_test.sv
// Self-checking testbench for date_difference_days: directed date pairs, then random traffic.
module date_difference_days_test;

   typedef logic [dd_pkg::YEAR_W-1:0]  year_type;
   typedef logic [dd_pkg::MONTH_W-1:0] month_type;
   typedef logic [dd_pkg::DAY_W-1:0]   day_type;

   localparam month_type MONTH_NONE = 4'd0;
   localparam month_type MONTH_OVER = 4'd13;
   localparam month_type MONTH_TOP  = 4'd15;
   localparam int unsigned SPAN_CAP = 3652426;
   localparam int unsigned MONTH_START [16] =
      '{0, 0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334, 0, 0, 0};

   typedef struct {
      year_type  first_year;
      month_type first_month;
      day_type   first_day;
      year_type  second_year;
      month_type second_month;
      day_type   second_day;
      logic      include_end;
   } date_pair_type;

   typedef struct packed {
      logic [dd_pkg::DIFF_W-1:0] day_difference;
      logic                      date_error;
   } day_count_type;

   typedef struct {
      date_pair_type dates;
      bit            typed;
      day_count_type want;
   } directed_row_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic        rsp_tuser;

   day_count_type expected_day_counts [$];
   int unsigned   mismatch_count = 0;
   bit            idling_on = 1'b1;
   bit            long_stall_pending = 1'b0;
   int unsigned   ready_hold_left = 0;
   int unsigned   ready_gap;

   directed_row_type directed_rows [23] = '{
      '{'{14'd2024, dd_pkg::MONTH_JAN, 5'd1, 14'd2024, dd_pkg::MONTH_JAN, 5'd1, 1'b0}, 1'b1,
        '{23'd0, 1'b0}},
      '{'{14'd2024, dd_pkg::MONTH_JAN, 5'd1, 14'd2024, dd_pkg::MONTH_JAN, 5'd1, 1'b1}, 1'b1,
        '{23'd1, 1'b0}},
      '{'{14'd2024, dd_pkg::MONTH_FEB, 5'd29, 14'd2024, dd_pkg::MONTH_FEB, 5'd29, 1'b1}, 1'b1,
        '{23'd1, 1'b0}},
      '{'{14'd1999, dd_pkg::MONTH_DEC, 5'd31, 14'd2000, dd_pkg::MONTH_JAN, 5'd1, 1'b0}, 1'b1,
        '{23'd1, 1'b0}},
      '{'{14'd2000, dd_pkg::MONTH_JAN, 5'd1, 14'd1999, dd_pkg::MONTH_DEC, 5'd31, 1'b1}, 1'b0,
        '{23'd0, 1'b0}},
      '{'{14'd0, dd_pkg::MONTH_JAN, 5'd1, 14'd9999, dd_pkg::MONTH_DEC, 5'd31, 1'b0}, 1'b0,
        '{23'd0, 1'b0}},
      '{'{14'd9999, dd_pkg::MONTH_DEC, 5'd31, 14'd0, dd_pkg::MONTH_JAN, 5'd1, 1'b1}, 1'b0,
        '{23'd0, 1'b0}},
      '{'{14'd0, dd_pkg::MONTH_JAN, 5'd1, 14'd16383, dd_pkg::MONTH_DEC, 5'd31, 1'b0}, 1'b1,
        '{23'sd3652426, 1'b0}},
      '{'{14'd16383, dd_pkg::MONTH_DEC, 5'd31, 14'd0, dd_pkg::MONTH_JAN, 5'd1, 1'b1}, 1'b1,
        '{-23'sd3652426, 1'b0}},
      '{'{14'd2024, MONTH_NONE, 5'd1, 14'd2024, dd_pkg::MONTH_JAN, 5'd1, 1'b0}, 1'b1,
        '{23'd0, 1'b1}},
      '{'{14'd2024, dd_pkg::MONTH_JAN, 5'd1, 14'd2024, MONTH_OVER, 5'd1, 1'b0}, 1'b1,
        '{23'd0, 1'b1}},
      '{'{14'd2024, MONTH_TOP, 5'd31, 14'd2024, dd_pkg::MONTH_JAN, 5'd1, 1'b1}, 1'b1,
        '{23'd0, 1'b1}},
      '{'{14'd2024, dd_pkg::MONTH_JAN, 5'd0, 14'd2024, dd_pkg::MONTH_JAN, 5'd1, 1'b0}, 1'b1,
        '{23'd0, 1'b1}},
      '{'{14'd2024, dd_pkg::MONTH_APR, 5'd31, 14'd2024, dd_pkg::MONTH_MAY, 5'd1, 1'b0}, 1'b1,
        '{23'd0, 1'b1}},
      '{'{14'd1900, dd_pkg::MONTH_FEB, 5'd29, 14'd1900, dd_pkg::MONTH_MAR, 5'd1, 1'b0}, 1'b1,
        '{23'd0, 1'b1}},
      '{'{14'd2000, dd_pkg::MONTH_MAR, 5'd1, 14'd2100, dd_pkg::MONTH_FEB, 5'd29, 1'b1}, 1'b1,
        '{23'd0, 1'b1}},
      '{'{14'd2024, dd_pkg::MONTH_FEB, 5'd30, 14'd2024, dd_pkg::MONTH_JUN, 5'd30, 1'b0}, 1'b1,
        '{23'd0, 1'b1}},
      '{'{14'd16383, MONTH_TOP, 5'd31, 14'd16383, MONTH_TOP, 5'd31, 1'b1}, 1'b1,
        '{23'd0, 1'b1}},
      '{'{14'd2000, dd_pkg::MONTH_FEB, 5'd29, 14'd2000, dd_pkg::MONTH_MAR, 5'd1, 1'b0}, 1'b0,
        '{23'd0, 1'b0}},
      '{'{14'd2024, dd_pkg::MONTH_FEB, 5'd29, 14'd2023, dd_pkg::MONTH_FEB, 5'd28, 1'b0}, 1'b0,
        '{23'd0, 1'b0}},
      '{'{14'd0, dd_pkg::MONTH_FEB, 5'd29, 14'd0, dd_pkg::MONTH_MAR, 5'd1, 1'b0}, 1'b0,
        '{23'd0, 1'b0}},
      '{'{14'd10000, dd_pkg::MONTH_JAN, 5'd1, 14'd9999, dd_pkg::MONTH_DEC, 5'd31, 1'b0}, 1'b0,
        '{23'd0, 1'b0}},
      '{'{14'd2023, dd_pkg::MONTH_DEC, 5'd31, 14'd2024, dd_pkg::MONTH_JUL, 5'd31, 1'b1}, 1'b0,
        '{23'd0, 1'b0}}
   };

   date_difference_days u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   function automatic bit is_leap_year(input int unsigned y);
      return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
   endfunction

   function automatic int unsigned days_in_month(input int unsigned y, input month_type m);
      if (m < dd_pkg::MONTH_JAN || m > dd_pkg::MONTH_DEC)
         return 0;
      if (m == dd_pkg::MONTH_FEB)
         return is_leap_year(y) ? 29 : 28;
      if (m == dd_pkg::MONTH_APR || m == dd_pkg::MONTH_JUN || m == dd_pkg::MONTH_SEP ||
          m == dd_pkg::MONTH_NOV)
         return 30;
      return 31;
   endfunction

   function automatic bit date_is_valid(input int unsigned y, input month_type m,
                                        input int unsigned d);
      int unsigned len;
      len = days_in_month(y, m);
      return len != 0 && d >= 1 && d <= len;
   endfunction

   function automatic int unsigned days_since_origin(input int unsigned y, input month_type m,
                                                     input int unsigned d);
      int unsigned leaps;
      int unsigned total;
      leaps = (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
      total = 365 * y + leaps + MONTH_START[m] + d - 1;
      if (m > dd_pkg::MONTH_FEB && is_leap_year(y))
         total = total + 1;
      return total;
   endfunction

   function automatic day_count_type predict_day_count(input date_pair_type p);
      int unsigned   from_days;
      int unsigned   to_days;
      int unsigned   span;
      bit            backward;
      day_count_type r;
      r = '0;
      if (!date_is_valid(p.first_year, p.first_month, p.first_day) ||
          !date_is_valid(p.second_year, p.second_month, p.second_day)) begin
         r.date_error = 1'b1;
         return r;
      end
      from_days = days_since_origin(p.first_year, p.first_month, p.first_day);
      to_days   = days_since_origin(p.second_year, p.second_month, p.second_day);
      backward  = from_days > to_days;
      span = backward ? from_days - to_days : to_days - from_days;
      span = span + p.include_end;
      if (span > SPAN_CAP)
         span = SPAN_CAP;
      if (backward)
         span = 32'd0 - span;
      r.day_difference = span[dd_pkg::DIFF_W-1:0];
      return r;
   endfunction

   function automatic logic [47:0] pack_dates(input date_pair_type p);
      return {2'b00, p.second_day, p.second_month, p.second_year,
              p.first_day, p.first_month, p.first_year};
   endfunction

   function automatic int unsigned idle_length();
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 60)
         return 0;
      if (pick < 92)
         return $urandom_range(3, 1);
      return $urandom_range(40, 8);
   endfunction

   function automatic year_type random_year();
      int unsigned pick;
      pick = $urandom_range(9);
      if (pick < 6)
         return dd_pkg::YEAR_W'($urandom_range(9999));
      if (pick < 9)
         return dd_pkg::YEAR_W'($urandom_range(2100, 1890));
      return dd_pkg::YEAR_W'($urandom_range(16383, 10000));
   endfunction

   function automatic void pick_date(input year_type y, output month_type m, output day_type d);
      m = dd_pkg::MONTH_W'($urandom_range(12, 1));
      d = dd_pkg::DAY_W'($urandom_range(days_in_month(y, m), 1));
   endfunction

   function automatic date_pair_type random_dates();
      date_pair_type p;
      int unsigned   shape;
      shape = $urandom_range(99);
      p.first_year = random_year();
      pick_date(p.first_year, p.first_month, p.first_day);
      p.second_year = random_year();
      pick_date(p.second_year, p.second_month, p.second_day);
      p.include_end = 1'($urandom_range(1));
      if (shape < 12) begin
         p.first_year   = dd_pkg::YEAR_W'($urandom_range(16383));
         p.first_month  = dd_pkg::MONTH_W'($urandom_range(15));
         p.first_day    = dd_pkg::DAY_W'($urandom_range(31));
         p.second_year  = dd_pkg::YEAR_W'($urandom_range(16383));
         p.second_month = dd_pkg::MONTH_W'($urandom_range(15));
         p.second_day   = dd_pkg::DAY_W'($urandom_range(31));
      end else if (shape < 22) begin
         case ($urandom_range(3))
            0: p.first_day = dd_pkg::DAY_W'(days_in_month(p.first_year, p.first_month) + 1);
            1: p.second_day = '0;
            2: p.first_month = MONTH_NONE;
            default: p.second_month = dd_pkg::MONTH_W'($urandom_range(15, 13));
         endcase
      end else if (shape < 30) begin
         p.second_year  = p.first_year;
         p.second_month = p.first_month;
         p.second_day   = p.first_day;
      end else if (shape < 60) begin
         p.second_year = p.first_year + dd_pkg::YEAR_W'($urandom_range(1));
         pick_date(p.second_year, p.second_month, p.second_day);
      end
      return p;
   endfunction

   task automatic report_mismatch(input string what, input day_count_type want);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("%0t: %s: expected diff %0d err %0b, got diff %0d err %0b", $realtime, what,
                  $signed(want.day_difference), want.date_error,
                  $signed(rsp_tdata[dd_pkg::DIFF_W-1:0]), rsp_tuser);
   endtask

   task automatic check_day_count();
      day_count_type want;
      if (expected_day_counts.size() == 0) begin
         report_mismatch("unexpected transaction", '0);
         return;
      end
      want = expected_day_counts.pop_front();
      if (rsp_tdata[dd_pkg::DIFF_W-1:0] !== want.day_difference ||
          rsp_tuser !== want.date_error)
         report_mismatch("mismatch", want);
   endtask

   task automatic send_dates(input date_pair_type p, input bit typed, input day_count_type want,
                             input bit allow_gap);
      int unsigned gap;
      gap = (allow_gap && idling_on) ? idle_length() : 0;
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tdata  <= pack_dates(p);
      req_tuser  <= p.include_end;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      expected_day_counts.push_back(typed ? want : predict_day_count(p));
   endtask

   task automatic drain_results();
      while (expected_day_counts.size() != 0) @(posedge clock);
   endtask

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("FAIL date_difference_days");
      $finish;
   end

   // drive rsp_tready and check every rsp transaction
   initial begin
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready)
            check_day_count();
         if (ready_hold_left != 0) begin
            ready_hold_left--;
            rsp_tready <= 1'b0;
         end else if (long_stall_pending) begin
            long_stall_pending = 1'b0;
            ready_hold_left = 59;
            rsp_tready <= 1'b0;
         end else begin
            ready_gap = idling_on ? idle_length() : 0;
            if (ready_gap == 0) begin
               rsp_tready <= 1'b1;
            end else begin
               ready_hold_left = ready_gap - 1;
               rsp_tready <= 1'b0;
            end
         end
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      foreach (directed_rows[i])
         send_dates(directed_rows[i].dates, directed_rows[i].typed, directed_rows[i].want, 1'b1);
      repeat (400) send_dates(random_dates(), 1'b0, '0, 1'b1);
      // hold the receiver off while offering back to back to fill the pipeline
      long_stall_pending = 1'b1;
      repeat (24) send_dates(random_dates(), 1'b0, '0, 1'b0);
      req_tvalid <= 1'b0;
      drain_results();
      idling_on = 1'b0;
      repeat (300) send_dates(random_dates(), 1'b0, '0, 1'b1);
      idling_on = 1'b1;
      repeat (330) send_dates(random_dates(), 1'b0, '0, 1'b1);
      req_tvalid <= 1'b0;
      drain_results();
      repeat (10) @(posedge clock);
      if (mismatch_count == 0 && expected_day_counts.size() == 0)
         $display("PASS date_difference_days");
      else
         $display("FAIL date_difference_days");
      $finish;
   end

endmodule

### filelist.f
+incdir+rtl/core
rtl/core/dd_pkg.sv
rtl/core/dd_day_count.sv
rtl/core/dd_diff.sv
rtl/core/date_difference_days.sv
tb/date_difference_days_test.sv
